// File: design/json_string_unescape_decoder_macros.svh
// Assertion macros for the JSON string decoder, used by jsud_emit.
`ifndef JSON_STRING_UNESCAPE_DECODER_MACROS_SVH
`define JSON_STRING_UNESCAPE_DECODER_MACROS_SVH

// Same-cycle implication, muted during reset.
`define JSUD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted during reset.
`define JSUD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/jsud_pkg.sv
// Shared types, codes and decode helpers for the JSON string decoder.
`timescale 1ns / 1ps
`default_nettype none

package jsud_pkg;

  localparam int OFFSET_BITS_DEF = 24;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } jsud_kind_t;

  typedef enum logic [2:0] {
    ERR_CTRL   = 3'd0,
    ERR_ESC    = 3'd1,
    ERR_UNI    = 3'd2,
    ERR_UTF8   = 3'd3,
    ERR_UNTERM = 3'd4
  } jsud_err_t;

  // Second-byte range of a multibyte sequence
  typedef enum logic [1:0] {
    BND_FULL  = 2'd0,  // 80..BF
    BND_RAISE = 2'd1,  // A0..BF or 90..BF
    BND_CUT   = 2'd2   // 80..9F or 80..8F
  } jsud_bounds_t;

  // Result group of one input transaction: up to four bytes, or one status
  typedef struct packed {
    logic [2:0]       count;
    jsud_kind_t       kind;
    logic [3:0][7:0]  bytes;
    jsud_err_t        code;
  } jsud_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } jsud_hex_t;

  typedef struct packed {
    logic         ok;
    logic [1:0]   rem;
    jsud_bounds_t bounds;
  } jsud_lead_t;

  typedef struct packed {
    logic [2:0]      count;
    logic [3:0][7:0] bytes;
  } jsud_enc_t;

  function automatic jsud_hex_t hex_info(input logic [7:0] b);
    jsud_hex_t h;
    h.ok  = 1'b1;
    h.val = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.val = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      h.val = 4'(b[2:0] + 3'd1) + 4'd8;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic jsud_lead_t lead_info(input logic [7:0] b);
    jsud_lead_t l;
    l.ok     = 1'b1;
    l.rem    = 2'd0;
    l.bounds = BND_FULL;
    if (b >= 8'hC2 && b <= 8'hDF) begin
      l.rem = 2'd1;
    end else if (b == 8'hE0) begin
      l.rem = 2'd2;
      l.bounds = BND_RAISE;
    end else if (b == 8'hED) begin
      l.rem = 2'd2;
      l.bounds = BND_CUT;
    end else if (b >= 8'hE1 && b <= 8'hEF) begin
      l.rem = 2'd2;
    end else if (b == 8'hF0) begin
      l.rem = 2'd3;
      l.bounds = BND_RAISE;
    end else if (b == 8'hF4) begin
      l.rem = 2'd3;
      l.bounds = BND_CUT;
    end else if (b >= 8'hF1 && b <= 8'hF3) begin
      l.rem = 2'd3;
    end else begin
      l.ok = 1'b0;
    end
    return l;
  endfunction

  // UTF-8 encoding of a code point, first byte in bytes[0]
  function automatic jsud_enc_t utf8_encode(input logic [20:0] cp);
    jsud_enc_t e;
    e.bytes = '0;
    if (cp <= 21'h7F) begin
      e.count    = 3'd1;
      e.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      e.count    = 3'd2;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      e.count    = 3'd3;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      e.count    = 3'd4;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// File: design/jsud_decode.sv
// Decode state and per-byte next-state / result logic.
`timescale 1ns / 1ps
`default_nettype none

module jsud_decode #(
  parameter int OFFSET_BITS = jsud_pkg::OFFSET_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    advance,
  input  wire [7:0]              in_byte,
  input  wire                    in_end,
  output jsud_pkg::jsud_res_t    res,
  output logic [OFFSET_BITS-1:0] res_off
);
  import jsud_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef enum logic [3:0] {
    PH_BODY, PH_ESC, PH_HEX1, PH_WANT_BS, PH_WANT_U,
    PH_HEX2, PH_UTF8, PH_DEFER, PH_DONE
  } phase_t;

  phase_t                 phase, phase_next;
  logic [15:0]            hex_accum, hex_accum_next;
  logic [1:0]             hex_count, hex_count_next;
  logic [9:0]             high_half, high_half_next;
  logic [OFFSET_BITS-1:0] digits_start, digits_start_next;
  logic [1:0]             utf8_remaining, utf8_remaining_next;
  jsud_bounds_t           second_bounds, second_bounds_next;
  jsud_err_t              defer_code, defer_code_next;
  logic [OFFSET_BITS-1:0] defer_off, defer_off_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;

  jsud_hex_t              hexd;
  jsud_lead_t             lead;
  jsud_enc_t              enc;
  logic [15:0]            acc_new;
  logic                   unit_done;
  logic [20:0]            cp;
  logic [7:0]             cont_lo, cont_hi;
  logic                   cont_ok;
  logic [1:0]             rem_dec;
  logic                   syn_fire;
  jsud_err_t              syn_code;
  logic                   fail_fire;
  jsud_err_t              fail_code;
  logic [OFFSET_BITS-1:0] fail_off;

  always_comb begin
    hexd      = hex_info(in_byte);
    lead      = lead_info(in_byte);
    acc_new   = (hex_count == 2'd0) ? {12'h000, hexd.val} : {hex_accum[11:0], hexd.val};
    unit_done = hexd.ok && (hex_count == 2'd3);
    if (phase == PH_HEX2) begin
      cp = 21'h10000 + {1'b0, high_half, acc_new[9:0]};
    end else begin
      cp = {5'd0, acc_new};
    end
    enc = utf8_encode(cp);

    cont_lo = 8'h80;
    cont_hi = 8'hBF;
    if (second_bounds == BND_RAISE) begin
      cont_lo = (utf8_remaining == 2'd2) ? 8'hA0 : 8'h90;
    end else if (second_bounds == BND_CUT) begin
      cont_hi = (utf8_remaining == 2'd2) ? 8'h9F : 8'h8F;
    end
    cont_ok = (in_byte >= cont_lo) && (in_byte <= cont_hi);
    rem_dec = (utf8_remaining == 2'd0) ? 2'd0 : utf8_remaining - 2'd1;
  end

  always_comb begin
    phase_next          = phase;
    hex_accum_next      = hex_accum;
    hex_count_next      = hex_count;
    high_half_next      = high_half;
    digits_start_next   = digits_start;
    utf8_remaining_next = utf8_remaining;
    second_bounds_next  = second_bounds;
    defer_code_next     = defer_code;
    defer_off_next      = defer_off;
    byte_offset_next    = byte_offset;
    res                 = '0;
    res.kind            = KIND_BYTE;
    res.code            = ERR_CTRL;
    res_off             = '0;
    syn_fire            = 1'b0;
    syn_code            = ERR_ESC;
    fail_fire           = 1'b0;
    fail_code           = ERR_CTRL;
    fail_off            = byte_offset;

    if (in_end) begin
      unique case (phase)
        PH_BODY: begin
          fail_fire = 1'b1;
          fail_code = ERR_UNTERM;
        end
        PH_ESC: begin
          fail_fire = 1'b1;
          fail_code = ERR_ESC;
        end
        PH_HEX1, PH_WANT_BS, PH_WANT_U, PH_HEX2: begin
          fail_fire = 1'b1;
          fail_code = ERR_UNI;
        end
        PH_UTF8, PH_DEFER: begin
          fail_fire = 1'b1;
          fail_code = ERR_UTF8;
        end
        default: ;
      endcase
    end else begin
      if (byte_offset != '1) begin
        byte_offset_next = byte_offset + 1'b1;
      end
      unique case (phase)
        PH_BODY: begin
          if (in_byte == CH_QUOTE) begin
            res.count  = 3'd1;
            res.kind   = KIND_CLOSE;
            phase_next = PH_DONE;
          end else if (in_byte < 8'h20) begin
            fail_fire = 1'b1;
            fail_code = ERR_CTRL;
          end else if (in_byte == CH_BSLASH) begin
            phase_next = PH_ESC;
          end else if (in_byte <= 8'h7F) begin
            res.count    = 3'd1;
            res.bytes[0] = in_byte;
          end else if (!lead.ok) begin
            fail_fire = 1'b1;
            fail_code = ERR_UTF8;
          end else begin
            res.count           = 3'd1;
            res.bytes[0]        = in_byte;
            utf8_remaining_next = lead.rem;
            second_bounds_next  = lead.bounds;
            phase_next          = PH_UTF8;
          end
        end
        PH_ESC: begin
          phase_next = PH_BODY;
          res.count  = 3'd1;
          unique case (in_byte)
            CH_QUOTE, CH_BSLASH, CH_SLASH: res.bytes[0] = in_byte;
            CH_B: res.bytes[0] = 8'h08;
            CH_F: res.bytes[0] = 8'h0C;
            CH_N: res.bytes[0] = 8'h0A;
            CH_R: res.bytes[0] = 8'h0D;
            CH_T: res.bytes[0] = 8'h09;
            CH_U: begin
              res.count      = 3'd0;
              phase_next     = PH_HEX1;
              hex_count_next = 2'd0;
              hex_accum_next = 16'h0000;
            end
            default: begin
              res.count = 3'd0;
              syn_fire  = 1'b1;
              syn_code  = ERR_ESC;
            end
          endcase
        end
        PH_HEX1, PH_HEX2: begin
          if (!hexd.ok) begin
            syn_fire = 1'b1;
            syn_code = ERR_UNI;
          end else begin
            if (hex_count == 2'd0) begin
              digits_start_next = byte_offset;
            end
            hex_accum_next = acc_new;
            hex_count_next = hex_count + 2'd1;
            if (unit_done) begin
              if (phase == PH_HEX1) begin
                if (acc_new >= 16'hDC00) begin
                  if (acc_new <= 16'hDFFF) begin
                    fail_fire = 1'b1;
                    fail_code = ERR_UNI;
                    fail_off  = digits_start;
                  end else begin
                    res.count  = enc.count;
                    res.bytes  = enc.bytes;
                    phase_next = PH_BODY;
                  end
                end else if (acc_new >= 16'hD800) begin
                  high_half_next = acc_new[9:0];
                  phase_next     = PH_WANT_BS;
                end else begin
                  res.count  = enc.count;
                  res.bytes  = enc.bytes;
                  phase_next = PH_BODY;
                end
              end else if (acc_new < 16'hDC00 || acc_new > 16'hDFFF) begin
                fail_fire = 1'b1;
                fail_code = ERR_UNI;
                fail_off  = digits_start;
              end else begin
                res.count  = enc.count;
                res.bytes  = enc.bytes;
                phase_next = PH_BODY;
              end
            end
          end
        end
        PH_WANT_BS: begin
          if (in_byte == CH_BSLASH) begin
            phase_next = PH_WANT_U;
          end else begin
            syn_fire = 1'b1;
            syn_code = ERR_UNI;
          end
        end
        PH_WANT_U: begin
          if (in_byte == CH_U) begin
            phase_next     = PH_HEX2;
            hex_count_next = 2'd0;
            hex_accum_next = 16'h0000;
          end else begin
            syn_fire = 1'b1;
            syn_code = ERR_UNI;
          end
        end
        PH_UTF8, PH_DEFER: begin
          if (!cont_ok) begin
            fail_fire = 1'b1;
            fail_code = ERR_UTF8;
          end else begin
            if (phase == PH_UTF8) begin
              res.count    = 3'd1;
              res.bytes[0] = in_byte;
            end
            second_bounds_next  = BND_FULL;
            utf8_remaining_next = rem_dec;
            if (rem_dec == 2'd0) begin
              if (phase == PH_DEFER) begin
                fail_fire = 1'b1;
                fail_code = defer_code;
                fail_off  = defer_off;
              end else begin
                phase_next = PH_BODY;
              end
            end
          end
        end
        default: ;
      endcase

      // A syntax error at a high byte waits for that byte's UTF-8 sequence
      if (syn_fire) begin
        if (in_byte < 8'h80) begin
          fail_fire = 1'b1;
          fail_code = syn_code;
        end else if (!lead.ok) begin
          fail_fire = 1'b1;
          fail_code = ERR_UTF8;
        end else begin
          utf8_remaining_next = lead.rem;
          second_bounds_next  = lead.bounds;
          defer_code_next     = syn_code;
          defer_off_next      = byte_offset;
          phase_next          = PH_DEFER;
        end
      end
    end

    if (fail_fire) begin
      res.count    = 3'd1;
      res.kind     = KIND_ERROR;
      res.bytes    = '0;
      res.code     = fail_code;
      res_off      = fail_off;
      phase_next   = PH_DONE;
    end

    // End of text: back to a fresh string body
    if (in_end) begin
      phase_next          = PH_BODY;
      hex_accum_next      = 16'h0000;
      hex_count_next      = 2'd0;
      high_half_next      = 10'd0;
      digits_start_next   = '0;
      utf8_remaining_next = 2'd0;
      second_bounds_next  = BND_FULL;
      defer_code_next     = ERR_CTRL;
      defer_off_next      = '0;
      byte_offset_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_BODY;
      hex_accum      <= 16'h0000;
      hex_count      <= 2'd0;
      high_half      <= 10'd0;
      digits_start   <= '0;
      utf8_remaining <= 2'd0;
      second_bounds  <= BND_FULL;
      defer_code     <= ERR_CTRL;
      defer_off      <= '0;
      byte_offset    <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      hex_accum      <= hex_accum_next;
      hex_count      <= hex_count_next;
      high_half      <= high_half_next;
      digits_start   <= digits_start_next;
      utf8_remaining <= utf8_remaining_next;
      second_bounds  <= second_bounds_next;
      defer_code     <= defer_code_next;
      defer_off      <= defer_off_next;
      byte_offset    <= byte_offset_next;
    end
  end

endmodule

`default_nettype wire

// File: design/jsud_emit.sv
// Result register: holds one result group and sends it out a byte per transaction.
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_unescape_decoder_macros.svh"

module jsud_emit #(
  parameter int OFFSET_BITS = jsud_pkg::OFFSET_BITS_DEF,
  parameter int TDATA_W     = ((11 + OFFSET_BITS + 7) / 8) * 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          load,
  input  jsud_pkg::jsud_res_t          res,
  input  wire [OFFSET_BITS-1:0]        res_off,
  output logic                         load_ready,
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [TDATA_W-1:0]           m_tdata,
  output logic [1:0]                   m_tuser,
  output logic                         m_tlast
);
  import jsud_pkg::*;

  logic                   valid;
  logic [2:0]             rem;
  jsud_kind_t             kind;
  logic [3:0][7:0]        bytes;
  jsud_err_t              code;
  logic [OFFSET_BITS-1:0] offset;

  assign m_tvalid   = valid;
  assign m_tlast    = (rem == 3'd1);
  assign m_tuser    = kind;
  assign m_tdata    = TDATA_W'({offset, code, bytes[0]});
  assign load_ready = !valid || (m_tready && (rem == 3'd1));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rem   <= 3'd0;
    end else if (load && load_ready && (res.count != 3'd0)) begin
      valid <= 1'b1;
      rem   <= res.count;
    end else if (valid && m_tready) begin
      // drop the group after its last byte, else advance
      valid <= (rem != 3'd1);
      rem   <= rem - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready && (res.count != 3'd0)) begin
      kind   <= res.kind;
      bytes  <= res.bytes;
      code   <= res.code;
      offset <= res_off;
    end else if (valid && m_tready) begin
      bytes <= {8'h00, bytes[3:1]};
    end
  end

  `JSUD_ASSERT_IMPL(a_load_when_free, clk, rst, load && (res.count != 3'd0), !valid || (m_tready && (rem == 3'd1)), "group loaded over a pending one")
  `JSUD_ASSERT_IMPL(a_rem_range, clk, rst, valid, (rem != 3'd0) && (rem <= 3'd4), "result count out of range")
  `JSUD_ASSERT_IMPL(a_status_alone, clk, rst, valid && (kind != KIND_BYTE), rem == 3'd1, "close or error not alone")
  `JSUD_ASSERT_NEXT(a_rem_steps, clk, rst, valid && m_tready && (rem != 3'd1), valid && (rem == $past(rem) - 3'd1), "group lost or skipped a byte")

endmodule

`default_nettype wire

// File: design/json_string_unescape_decoder.sv
// Top level of the JSON string body decoder.
// Decodes a JSON string body (bytes after the opening quote) into UTF-8 bytes,
// one input byte per transaction with tlast marking end of text. Each input
// transaction gives zero to four result transactions; the last one of them
// carries tlast. A byte that yields at most one result moves at one per cycle
// while m_tready is high; a \u escape that expands to n UTF-8 bytes holds the
// input until the result register, which sends one byte per cycle while m_tready
// is high, has sent them all. Path: input register, then result register.
// After a close or an error, bytes give no results until tlast returns the
// decoder to a fresh string. Error offsets saturate at 2^OFFSET_BITS-1.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_decoder #(
  parameter int OFFSET_BITS = jsud_pkg::OFFSET_BITS_DEF,
  parameter int TDATA_W     = ((11 + OFFSET_BITS + 7) / 8) * 8
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                s_tvalid,
  output logic               s_tready,
  input  wire [7:0]          s_tdata,   // [7:0] in_byte
  input  wire                s_tlast,   // text_end
  output logic               m_tvalid,
  input  wire                m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [7:0] out_byte, [10:8] error_code,
                                        // [10+OFFSET_BITS:11] error_offset, zero pad
  output logic [1:0]         m_tuser,   // [1:0] kind
  output logic               m_tlast    // last
);
  import jsud_pkg::*;

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   in_end;
  logic                   load_ready;
  logic                   advance;
  jsud_res_t              res;
  logic [OFFSET_BITS-1:0] res_off;

  assign advance  = in_valid && load_ready;
  assign s_tready = !in_valid || load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_end  <= s_tlast;
    end
  end

  jsud_decode #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_byte (in_byte),
    .in_end  (in_end),
    .res     (res),
    .res_off (res_off)
  );

  jsud_emit #(
    .OFFSET_BITS (OFFSET_BITS),
    .TDATA_W     (TDATA_W)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .res        (res),
    .res_off    (res_off),
    .load_ready (load_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for the JSON string body decoder: random string traffic against a predictor.
`timescale 1ns / 1ps

module tb;
  import jsud_pkg::*;

  localparam int OFF_W       = OFFSET_BITS_DEF;
  localparam int OFF_LSB     = 11;
  localparam int TDATA_W     = ((11 + OFF_W + 7) / 8) * 8;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 330;
  localparam int LONG_HOLD   = 300;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [3:0] {
    ST_BODY, ST_ESC, ST_HEX1, ST_WANT_BS, ST_WANT_U, ST_HEX2, ST_UTF8, ST_DEFER, ST_DONE
  } decode_phase_t;

  typedef struct {
    jsud_kind_t       kind;
    logic [7:0]       data;
    jsud_err_t        code;
    logic [OFF_W-1:0] off;
    logic             is_last;
  } decoded_t;

  // UTF-8 bytes of a code point, lead byte in seq[0]; returns the byte count
  function automatic int encode_utf8(input logic [20:0] cp, output logic [3:0][7:0] seq);
    seq = '0;
    if (cp < 21'h80) begin
      seq[0] = cp[7:0];
      return 1;
    end
    if (cp < 21'h800) begin
      seq[0] = 8'hC0 | 8'(cp >> 6);
      seq[1] = 8'h80 | 8'(cp & 21'h3F);
      return 2;
    end
    if (cp < 21'h10000) begin
      seq[0] = 8'hE0 | 8'(cp >> 12);
      seq[1] = 8'h80 | 8'((cp >> 6) & 21'h3F);
      seq[2] = 8'h80 | 8'(cp & 21'h3F);
      return 3;
    end
    seq[0] = 8'hF0 | 8'((cp >> 18) & 21'h07);
    seq[1] = 8'h80 | 8'((cp >> 12) & 21'h3F);
    seq[2] = 8'h80 | 8'((cp >> 6) & 21'h3F);
    seq[3] = 8'h80 | 8'(cp & 21'h3F);
    return 4;
  endfunction

  class decode_scoreboard;
    decode_phase_t    phase;
    logic [15:0]      hex_acc;
    int unsigned      hex_n;
    logic [9:0]       high_half;
    logic [OFF_W-1:0] digits_at;
    int unsigned      cont_left;
    jsud_bounds_t     bounds;
    jsud_err_t        held_code;
    logic [OFF_W-1:0] held_off;
    logic [OFF_W-1:0] offset;
    decoded_t         due[$];
    int               errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase     = ST_BODY;
      hex_acc   = '0;
      hex_n     = 0;
      high_half = '0;
      digits_at = '0;
      cont_left = 0;
      bounds    = BND_FULL;
      held_code = ERR_CTRL;
      held_off  = '0;
      offset    = '0;
    endfunction

    function void push(jsud_kind_t k, logic [7:0] b, jsud_err_t c, logic [OFF_W-1:0] off);
      decoded_t r;
      r.kind    = k;
      r.data    = b;
      r.code    = c;
      r.off     = off;
      r.is_last = 1'b0;
      due.insert(due.size(), r);
    endfunction

    function void fail(jsud_err_t c, logic [OFF_W-1:0] off);
      push(KIND_ERROR, 8'h00, c, off);
      phase = ST_DONE;
    endfunction

    // Continuation bytes that follow a lead byte; 0 for a byte that cannot lead
    function int unsigned seq_tail(logic [7:0] b, output jsud_bounds_t bnd);
      bnd = BND_FULL;
      if (b >= 8'hC2 && b <= 8'hDF) return 1;
      if (b == 8'hE0) begin
        bnd = BND_RAISE;
        return 2;
      end
      if (b == 8'hED) begin
        bnd = BND_CUT;
        return 2;
      end
      if (b >= 8'hE1 && b <= 8'hEF) return 2;
      if (b == 8'hF0) begin
        bnd = BND_RAISE;
        return 3;
      end
      if (b == 8'hF4) begin
        bnd = BND_CUT;
        return 3;
      end
      if (b >= 8'hF1 && b <= 8'hF3) return 3;
      return 0;
    endfunction

    function bit cont_fits(logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = 8'h80;
      hi = 8'hBF;
      if (bounds == BND_RAISE) lo = (cont_left == 2) ? 8'hA0 : 8'h90;
      else if (bounds == BND_CUT) hi = (cont_left == 2) ? 8'h9F : 8'h8F;
      return b >= lo && b <= hi;
    endfunction

    // A syntax error at a high byte waits until its UTF-8 sequence is known good
    function void syntax_error(jsud_err_t c, logic [7:0] b);
      jsud_bounds_t bnd;
      int unsigned  n;
      if (b < 8'h80) begin
        fail(c, offset);
        return;
      end
      n = seq_tail(b, bnd);
      if (n == 0) begin
        fail(ERR_UTF8, offset);
        return;
      end
      cont_left = n;
      bounds    = bnd;
      held_code = c;
      held_off  = offset;
      phase     = ST_DEFER;
    endfunction

    function void emit_code_point(logic [20:0] cp);
      logic [3:0][7:0] seq;
      int              n;
      n = encode_utf8(cp, seq);
      for (int i = 0; i < n; i++) push(KIND_BYTE, seq[i], ERR_CTRL, '0);
    endfunction

    // Returns 1 when the fourth digit completes a code unit
    function bit take_hex(logic [7:0] b);
      logic [3:0] d;
      if (b >= "0" && b <= "9") d = 4'(b - "0");
      else if (b >= "a" && b <= "f") d = 4'(b - "a" + 10);
      else if (b >= "A" && b <= "F") d = 4'(b - "A" + 10);
      else begin
        syntax_error(ERR_UNI, b);
        return 1'b0;
      end
      if (hex_n == 0) begin
        digits_at = offset;
        hex_acc   = '0;
      end
      hex_acc = {hex_acc[11:0], d};
      hex_n++;
      if (hex_n < 4) return 1'b0;
      hex_n = 0;
      return 1'b1;
    endfunction

    function void step_byte(logic [7:0] b);
      jsud_bounds_t bnd;
      int unsigned  n;
      case (phase)
        ST_BODY: begin
          if (b == CH_QUOTE) begin
            push(KIND_CLOSE, 8'h00, ERR_CTRL, '0);
            phase = ST_DONE;
          end else if (b < 8'h20) begin
            fail(ERR_CTRL, offset);
          end else if (b == CH_BSLASH) begin
            phase = ST_ESC;
          end else if (b <= 8'h7F) begin
            push(KIND_BYTE, b, ERR_CTRL, '0);
          end else begin
            n = seq_tail(b, bnd);
            if (n == 0) begin
              fail(ERR_UTF8, offset);
            end else begin
              push(KIND_BYTE, b, ERR_CTRL, '0);
              cont_left = n;
              bounds    = bnd;
              phase     = ST_UTF8;
            end
          end
        end
        ST_ESC: begin
          phase = ST_BODY;
          case (b)
            CH_QUOTE, CH_BSLASH, "/": push(KIND_BYTE, b, ERR_CTRL, '0);
            "b": push(KIND_BYTE, 8'h08, ERR_CTRL, '0);
            "f": push(KIND_BYTE, 8'h0C, ERR_CTRL, '0);
            "n": push(KIND_BYTE, 8'h0A, ERR_CTRL, '0);
            "r": push(KIND_BYTE, 8'h0D, ERR_CTRL, '0);
            "t": push(KIND_BYTE, 8'h09, ERR_CTRL, '0);
            "u": begin
              phase   = ST_HEX1;
              hex_n   = 0;
              hex_acc = '0;
            end
            default: syntax_error(ERR_ESC, b);
          endcase
        end
        ST_HEX1: begin
          if (take_hex(b)) begin
            if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
              fail(ERR_UNI, digits_at);
            end else if (hex_acc < 16'hD800 || hex_acc > 16'hDBFF) begin
              emit_code_point({5'd0, hex_acc});
              phase = ST_BODY;
            end else begin
              high_half = hex_acc[9:0];
              phase     = ST_WANT_BS;
            end
          end
        end
        ST_WANT_BS: begin
          if (b == CH_BSLASH) phase = ST_WANT_U;
          else syntax_error(ERR_UNI, b);
        end
        ST_WANT_U: begin
          if (b == "u") begin
            phase   = ST_HEX2;
            hex_n   = 0;
            hex_acc = '0;
          end else begin
            syntax_error(ERR_UNI, b);
          end
        end
        ST_HEX2: begin
          if (take_hex(b)) begin
            if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
              fail(ERR_UNI, digits_at);
            end else begin
              emit_code_point(21'h10000 + {1'b0, high_half, hex_acc[9:0]});
              phase = ST_BODY;
            end
          end
        end
        ST_UTF8, ST_DEFER: begin
          if (!cont_fits(b)) begin
            fail(ERR_UTF8, offset);
          end else begin
            if (phase == ST_UTF8) push(KIND_BYTE, b, ERR_CTRL, '0);
            bounds = BND_FULL;
            if (cont_left > 0) cont_left--;
            if (cont_left == 0) begin
              if (phase == ST_DEFER) fail(held_code, held_off);
              else phase = ST_BODY;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void step_end();
      case (phase)
        ST_BODY:                               fail(ERR_UNTERM, offset);
        ST_ESC:                                fail(ERR_ESC, offset);
        ST_HEX1, ST_WANT_BS, ST_WANT_U, ST_HEX2: fail(ERR_UNI, offset);
        ST_UTF8, ST_DEFER:                     fail(ERR_UTF8, offset);
        default: ;
      endcase
    endfunction

    // Note an accepted input transaction; returns 0 when the decoder just drops it
    function bit take_input(logic [7:0] b, logic text_end);
      int queued;
      bit live;
      queued = due.size();
      live   = text_end || phase != ST_DONE;
      if (text_end) begin
        step_end();
      end else begin
        step_byte(b);
        if (offset != '1) offset++;
      end
      if (due.size() > queued) due[due.size() - 1].is_last = 1'b1;
      if (text_end) restart();
      return live;
    endfunction

    function void check_output(logic [TDATA_W-1:0] tdata, logic [1:0] tuser, logic tlast);
      decoded_t w;
      if (due.size() == 0) begin
        $error("unexpected result: kind %0d tdata %h", tuser, tdata);
        errors++;
        return;
      end
      w = due.pop_front();
      if (tuser !== w.kind) begin
        $error("kind: expected %0d, actual %0d", w.kind, tuser);
        errors++;
      end
      if (tdata[7:0] !== w.data) begin
        $error("out_byte: expected %h, actual %h", w.data, tdata[7:0]);
        errors++;
      end
      if (tdata[10:8] !== w.code) begin
        $error("error_code: expected %0d, actual %0d", w.code, tdata[10:8]);
        errors++;
      end
      if (tdata[OFF_LSB +: OFF_W] !== w.off) begin
        $error("error_offset: expected %0d, actual %0d", w.off, tdata[OFF_LSB +: OFF_W]);
        errors++;
      end
      if (tlast !== w.is_last) begin
        $error("last: expected %0b, actual %0b", w.is_last, tlast);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;
  logic               s_tlast;
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;
  logic [1:0]         m_tuser;
  logic               m_tlast;

  decode_scoreboard sb = new();
  logic [7:0] body[$];
  int  live_items;
  int  eager_left;
  int  quiet;
  bit  calm;
  bit  long_hold;

  json_string_unescape_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short idle gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [20:0] rand_scalar();
    logic [20:0] cp;
    case ($urandom_range(0, 2))
      0: cp = 21'($urandom_range(16'h80, 16'h7FF));
      1: begin
        do cp = 21'($urandom_range(16'h800, 16'hFFFF));
        while (cp >= 21'hD800 && cp <= 21'hDFFF);
      end
      default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
    endcase
    return cp;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    body.insert(body.size(), b);
  endtask

  task automatic add_unit(input logic [15:0] u);
    add_byte(CH_BSLASH);
    add_byte("u");
    add_byte(hex_char(u[15:12]));
    add_byte(hex_char(u[11:8]));
    add_byte(hex_char(u[7:4]));
    add_byte(hex_char(u[3:0]));
  endtask

  task automatic add_utf8(input logic [20:0] cp);
    logic [3:0][7:0] seq;
    int              n;
    n = encode_utf8(cp, seq);
    for (int i = 0; i < n; i++) add_byte(seq[i]);
  endtask

  task automatic send_item(input logic [7:0] b, input logic text_end);
    int gap;
    gap = (calm || eager_left > 0) ? 0 : idle_len();
    if (eager_left > 0) eager_left--;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= text_end;
    do @(posedge clk); while (!s_tready);
    if (sb.take_input(b, text_end)) live_items++;
  endtask

  // Send the body, then the end-of-text transaction
  task automatic send_text();
    foreach (body[i]) send_item(body[i], 1'b0);
    send_item(8'($urandom), 1'b1);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.due.size() != 0);
  endtask

  // Result side: accept, idle, and one long hold-off on request
  initial begin
    int n;
    m_tready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        n = idle_len();
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(0, 4) == 0 ? 40 : $urandom_range(1, 10)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_output(m_tdata, m_tuser, m_tlast);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0][7:0] seq;
    logic [7:0]      b;
    logic [20:0]     cp;
    int              n;
    int              cut;
    bit              held_once;
    bit              drained_once;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = 8'h00;
    s_tlast      = 1'b0;
    live_items   = 0;
    eager_left   = 0;
    calm         = 1'b0;
    long_hold    = 1'b0;
    held_once    = 1'b0;
    drained_once = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Plain bytes, escaped zero, the highest surrogate pair, close, a dropped byte
    body = '{"A", 8'h7F, CH_BSLASH, "u", "0", "0", "0", "0",
             CH_BSLASH, "u", "D", "B", "F", "F", CH_BSLASH, "u", "d", "f", "f", "f",
             CH_QUOTE, 8'hFF};
    send_text();
    // Control byte at offset zero
    body = '{8'h1F};
    send_text();

    live_items = 0;
    while (live_items < RANDOM_ITEMS) begin
      if (!held_once && live_items > 110) begin
        held_once  = 1'b1;
        long_hold  = 1'b1;
        eager_left = 150;
      end
      if (!drained_once && live_items > 220) begin
        drained_once = 1'b1;
        drain();
      end else if ($urandom_range(0, 9) == 0) begin
        drain();
      end
      calm = ($urandom_range(0, 3) == 0);

      body.delete();
      repeat ($urandom_range(1, 6)) begin
        n = $urandom_range(0, 99);
        if (n < 30) begin
          do b = 8'($urandom_range(8'h20, 8'h7F));
          while (b == CH_QUOTE || b == CH_BSLASH);
          add_byte(b);
        end else if (n < 42) begin
          case ($urandom_range(0, 7))
            0: b = CH_QUOTE;
            1: b = CH_BSLASH;
            2: b = "/";
            3: b = "b";
            4: b = "f";
            5: b = "n";
            6: b = "r";
            default: b = "t";
          endcase
          add_byte(CH_BSLASH);
          add_byte(b);
        end else if (n < 54) begin
          case ($urandom_range(0, 3))
            0: cp = 21'($urandom_range(0, 16'h7F));
            1: cp = 21'($urandom_range(16'h80, 16'h7FF));
            2: cp = 21'($urandom_range(16'h800, 16'hD7FF));
            default: cp = 21'($urandom_range(16'hE000, 16'hFFFF));
          endcase
          add_unit(cp[15:0]);
        end else if (n < 62) begin
          add_unit(16'hD800 | 16'($urandom_range(0, 16'h3FF)));
          add_unit(16'hDC00 | 16'($urandom_range(0, 16'h3FF)));
        end else if (n < 78) begin
          add_utf8(rand_scalar());
        end else begin
          case ($urandom_range(0, 9))
            0: add_byte(8'($urandom));
            1: add_byte(8'($urandom_range(0, 8'h1F)));
            2: begin
              add_byte(CH_BSLASH);
              add_byte(8'($urandom));
            end
            // bad escape at a lead byte whose sequence then completes
            3: begin
              add_byte(CH_BSLASH);
              add_utf8(rand_scalar());
            end
            4: begin
              add_byte(CH_BSLASH);
              add_byte("u");
              repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom)));
              add_byte(8'($urandom));
            end
            5: add_unit(16'hDC00 | 16'($urandom_range(0, 16'h3FF)));
            6: begin
              add_unit(16'hD800 | 16'($urandom_range(0, 16'h3FF)));
              case ($urandom_range(0, 2))
                0: add_byte(8'($urandom));
                1: begin
                  add_byte(CH_BSLASH);
                  add_byte(8'($urandom));
                end
                default: add_unit(16'($urandom));
              endcase
            end
            // truncated raw sequence followed by anything
            7: begin
              n = encode_utf8(rand_scalar(), seq);
              for (int i = 0; i < n - 1; i++) add_byte(seq[i]);
              add_byte(8'($urandom));
            end
            8: begin
              if ($urandom_range(0, 1)) begin
                add_unit(16'hD800 | 16'($urandom_range(0, 16'h3FF)));
              end else begin
                add_byte(CH_BSLASH);
                add_byte("u");
              end
              n = encode_utf8(rand_scalar(), seq);
              for (int i = 0; i < n - 1; i++) add_byte(seq[i]);
              add_byte($urandom_range(0, 3) == 0 ? 8'($urandom) : seq[n-1]);
            end
            // strict second-byte limits
            default: begin
              case ($urandom_range(0, 3))
                0: add_byte(8'hE0);
                1: add_byte(8'hED);
                2: add_byte(8'hF0);
                default: add_byte(8'hF4);
              endcase
              add_byte(8'($urandom_range(8'h80, 8'hBF)));
              add_byte(8'($urandom_range(8'h80, 8'hBF)));
            end
          endcase
        end
      end
      if ($urandom_range(0, 4) != 0) begin
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
      end
      // cut the text short now and then to end inside an escape or sequence
      if ($urandom_range(0, 6) == 0) begin
        cut = $urandom_range(0, body.size());
        while (body.size() > cut) void'(body.pop_back());
      end
      send_text();
    end

    s_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
